### sv/tsml_pkg.sv
package tsml_pkg;

   // default build values
   localparam int HALF_PERIOD_TICKS_DEF = 16;
   localparam int WORD_BITS_DEF = 16;
   localparam int WORD_COUNT_DEF = 5;

   // transmit ring storage, fixed by the register map
   localparam int WORD_MAX = 5;
   localparam int WORD_IDX_W = 3;
   localparam int WORD_W = 16;
   localparam int TICKS_W = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int COUNT_W = 9;

   localparam logic [TICKS_W-1:0] IDLE_HOLD_RESET = 8'd32;
   localparam logic [TICKS_W-1:0] BIT_SPACING_RESET = 8'd16;
   localparam logic [TICKS_W-1:0] START_GAP_RESET = 8'd4;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [WORD_MAX-1:0] words_type;
   typedef logic [TICKS_W-1:0] ticks_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TX_WORD_0 = 4'd0,
      CSR_TX_WORD_1 = 4'd1,
      CSR_TX_WORD_2 = 4'd2,
      CSR_TX_WORD_3 = 4'd3,
      CSR_TX_WORD_4 = 4'd4,
      CSR_IDLE_HOLD = 4'd5,
      CSR_BIT_SPACING = 4'd6,
      CSR_START_GAP = 4'd7
   } csr_index_type;

   typedef struct packed {
      ticks_type idle_hold;
      ticks_type bit_spacing;
   } rx_cfg_type;

   typedef struct packed {
      logic      reload;
      ticks_type reload_ticks;
   } rx_ctrl_type;

   typedef struct packed {
      logic bit_valid;
      logic bit_value;
   } rx_out_type;

   typedef struct packed {
      logic      line;
      logic      start_valid;
      ticks_type low_byte;
   } tx_out_type;

   typedef struct packed {
      logic      tx_line;
      logic      rx_bit_valid;
      logic      rx_bit;
      logic      word_start_valid;
      ticks_type word_low_byte;
   } rsp_type;

endpackage

### sv/tsml_req_if.sv
interface tsml_req_if;
   logic valid;
   logic ready;
   logic rx_sample;

   modport source (output valid, output rx_sample, input ready);
   modport sink (input valid, input rx_sample, output ready);
endinterface

### sv/tsml_rsp_if.sv
interface tsml_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_line;
   logic       rx_bit_valid;
   logic       rx_bit;
   logic       word_start_valid;
   logic [7:0] word_low_byte;

   modport source (output valid, output tx_line, output rx_bit_valid, output rx_bit,
                   output word_start_valid, output word_low_byte, input ready);
   modport sink (input valid, input tx_line, input rx_bit_valid, input rx_bit,
                 input word_start_valid, input word_low_byte, output ready);
endinterface

### sv/tsml_csr_if.sv
interface tsml_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### sv/tsml_rx.sv
module tsml_rx (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 sample,
   input  tsml_pkg::rx_cfg_type  cfg,
   input  tsml_pkg::rx_ctrl_type ctrl,
   output tsml_pkg::rx_out_type  result
);
   import tsml_pkg::*;

   localparam logic [COUNT_W-1:0] SatCount = {COUNT_W{1'b1}};

   logic               cur_ff, cur_in;
   logic               sync_ff, sync_in;
   ticks_type          high_run_ff, high_run_in;
   logic               edge_ff, edge_in;
   logic [COUNT_W-1:0] countdown_ff, countdown_in;
   logic [COUNT_W-1:0] since_ff, since_in;

   always_comb begin
      cur_in = cur_ff;
      sync_in = sync_ff;
      high_run_in = high_run_ff;
      edge_in = edge_ff;
      countdown_in = countdown_ff;
      since_in = since_ff;
      result = '0;
      if (step) begin
         cur_in = sample;
         if (!sync_ff) begin
            // hunting: long high run, falling edge, then countdown
            if (cur_ff && sample && high_run_ff != {TICKS_W{1'b1}}) begin
               high_run_in = high_run_ff + 1'b1;
            end
            if (high_run_in > cfg.idle_hold) begin
               if (cur_ff && !sample) begin
                  edge_in = 1'b1;
               end
               if (edge_in && countdown_ff != '0) begin
                  countdown_in = countdown_ff - 1'b1;
               end
               if (countdown_in == '0) begin
                  sync_in = 1'b1;
                  countdown_in = {1'b0, cfg.idle_hold} + 1'b1;
                  high_run_in = '0;
                  edge_in = 1'b0;
                  since_in = {1'b0, cfg.bit_spacing} + 1'b1;
               end
            end
         end else begin
            if (sample != cur_ff && since_ff > {1'b0, cfg.bit_spacing}) begin
               since_in = '0;
               result.bit_valid = 1'b1;
               result.bit_value = sample;
            end else if (since_ff != SatCount) begin
               since_in = since_ff + 1'b1;
            end
         end
      end
      if (ctrl.reload) begin
         countdown_in = {1'b0, ctrl.reload_ticks} + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= 1'b0;
         sync_ff <= 1'b0;
         high_run_ff <= '0;
         edge_ff <= 1'b0;
         countdown_ff <= {1'b0, IDLE_HOLD_RESET} + 1'b1;
         since_ff <= '0;
      end else begin
         cur_ff <= cur_in;
         sync_ff <= sync_in;
         high_run_ff <= high_run_in;
         edge_ff <= edge_in;
         countdown_ff <= countdown_in;
         since_ff <= since_in;
      end
   end
endmodule

### sv/tsml_tx.sv
module tsml_tx #(
   parameter int HALF_PERIOD_TICKS = tsml_pkg::HALF_PERIOD_TICKS_DEF,
   parameter int WORD_BITS = tsml_pkg::WORD_BITS_DEF,
   parameter int WORD_COUNT = tsml_pkg::WORD_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  tsml_pkg::words_type words,
   input  tsml_pkg::ticks_type start_gap,
   output tsml_pkg::tx_out_type result
);
   import tsml_pkg::*;

   localparam int DIV_W = (HALF_PERIOD_TICKS > 1) ? $clog2(HALF_PERIOD_TICKS) : 1;
   localparam int POS_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int SEL_W = $clog2(WORD_W);

   logic [DIV_W-1:0]      div_ff, div_in;
   logic                  half_ff, half_in;
   ticks_type             gap_ff, gap_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [WORD_IDX_W-1:0] idx_ff, idx_in;
   logic                  line_ff, line_in;

   logic [DIV_W:0]        div_sum;
   logic [POS_W:0]        pos_sum;
   logic [WORD_IDX_W-1:0] idx_sum;
   logic [WORD_IDX_W-1:0] idx_next;
   logic [SEL_W-1:0]      bit_sel;
   word_type              cur_word;

   always_comb begin
      div_sum = {1'b0, div_ff} + 1'b1;
      pos_sum = {1'b0, pos_ff} + 1'b1;
      idx_sum = idx_ff + 1'b1;
      idx_next = (idx_sum >= WORD_IDX_W'(WORD_COUNT)) ? '0 : idx_sum;
      bit_sel = SEL_W'(pos_ff);
      cur_word = words[idx_ff];

      div_in = div_ff;
      half_in = half_ff;
      gap_in = gap_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      line_in = line_ff;
      result = '0;
      if (step) begin
         if (div_sum >= (DIV_W + 1)'(HALF_PERIOD_TICKS)) begin
            div_in = '0;
            half_in = !half_ff;
            if (gap_ff != '0) begin
               // start gap: high, then low once the gap count has reached 2 until data starts
               if (gap_ff == 8'd2) begin
                  line_in = 1'b0;
               end
               gap_in = gap_ff - 1'b1;
            end else begin
               line_in = cur_word[bit_sel] ^ half_in;
               if (!half_in) begin
                  if (pos_sum >= (POS_W + 1)'(WORD_BITS)) begin
                     pos_in = '0;
                     idx_in = idx_next;
                     result.start_valid = 1'b1;
                     result.low_byte = words[idx_next][TICKS_W-1:0];
                     gap_in = start_gap;
                     line_in = 1'b1;
                  end else begin
                     pos_in = pos_sum[POS_W-1:0];
                  end
               end
            end
         end else begin
            div_in = div_sum[DIV_W-1:0];
         end
      end
      result.line = line_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= '0;
         half_ff <= 1'b0;
         gap_ff <= '0;
         pos_ff <= '0;
         idx_ff <= '0;
         line_ff <= 1'b0;
      end else begin
         div_ff <= div_in;
         half_ff <= half_in;
         gap_ff <= gap_in;
         pos_ff <= pos_in;
         idx_ff <= idx_in;
         line_ff <= line_in;
      end
   end
endmodule

### sv/tick_sampled_manchester_link.sv
// tick-sampled manchester link: receiver and transmitter advanced by one sample tick
// per request on req_port (field rx_sample, the received line level at that tick)
// every request gives exactly one response on rsp_port: transmit line level,
// received bit strobe and value, and a word start strobe with the new word's low byte
// csr_port writes the transmit ring (index 0..4), the idle hold (5), the bit spacing (6)
// and the start gap (7); other indexes are dropped; csr_port is always ready, and the
// user must see that it is only written while no request is in flight (not enforced)
// latency: the response is registered and valid the cycle after the request unless the output is full
// throughput: one request per cycle while the skid slot is free; all tick work is a single pass of counter
// updates between the state registers and the response register
// a two-entry response buffer (output register plus skid slot) keeps requests
// flowing while a response waits; req_port.ready drops while the skid slot holds
// a response, which only happens after the receiver stalls with the output full
// reset (synchronous, active high) restores register defaults, puts the receiver
// back into hunt mode, restarts the transmit ring at word 0 and empties the buffer
module tick_sampled_manchester_link #(
   parameter int HALF_PERIOD_TICKS = tsml_pkg::HALF_PERIOD_TICKS_DEF,
   parameter int WORD_BITS = tsml_pkg::WORD_BITS_DEF,
   parameter int WORD_COUNT = tsml_pkg::WORD_COUNT_DEF
) (
   input logic       clock,
   input logic       reset,
   tsml_req_if.sink  req_port,
   tsml_rsp_if.source rsp_port,
   tsml_csr_if.sink  csr_port
);
   import tsml_pkg::*;

   // configuration registers
   words_type   words_ff;
   ticks_type   long_ff;
   ticks_type   short_ff;
   ticks_type   start_ff;

   // response buffer
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     skid_ff, skid_in;
   logic        skid_valid_ff, skid_valid_in;

   logic        req_take;
   logic        rsp_pop;
   logic        csr_write;
   rx_cfg_type  rx_cfg;
   rx_ctrl_type rx_ctrl;
   rx_out_type  rx_result;
   tx_out_type  tx_result;
   rsp_type     rsp_new;

   assign csr_write = csr_port.valid && csr_port.ready;
   assign csr_port.ready = 1'b1;

   // ready while the skid slot is free
   assign req_port.ready = !skid_valid_ff;
   assign req_take = req_port.valid && req_port.ready;
   assign rsp_pop = out_valid_ff && rsp_port.ready;

   assign rx_cfg.idle_hold = long_ff;
   assign rx_cfg.bit_spacing = short_ff;

   // writing the idle hold also reloads the sync countdown with the new value
   assign rx_ctrl.reload = csr_write && (csr_port.index == CSR_IDLE_HOLD);
   assign rx_ctrl.reload_ticks = csr_port.data[TICKS_W-1:0];

   tsml_rx u_rx (
      .clock  (clock),
      .reset  (reset),
      .step   (req_take),
      .sample (req_port.rx_sample),
      .cfg    (rx_cfg),
      .ctrl   (rx_ctrl),
      .result (rx_result)
   );

   tsml_tx #(
      .HALF_PERIOD_TICKS (HALF_PERIOD_TICKS),
      .WORD_BITS         (WORD_BITS),
      .WORD_COUNT        (WORD_COUNT)
   ) u_tx (
      .clock     (clock),
      .reset     (reset),
      .step      (req_take),
      .words     (words_ff),
      .start_gap (start_ff),
      .result    (tx_result)
   );

   always_comb begin
      rsp_new.tx_line = tx_result.line;
      rsp_new.rx_bit_valid = rx_result.bit_valid;
      rsp_new.rx_bit = rx_result.bit_value;
      rsp_new.word_start_valid = tx_result.start_valid;
      rsp_new.word_low_byte = tx_result.low_byte;
   end

   // response buffer steering
   always_comb begin
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      skid_in = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (req_take) begin
         if (!out_valid_ff || rsp_pop) begin
            // output slot free or emptying this cycle
            out_in = rsp_new;
            out_valid_in = 1'b1;
         end else begin
            // receiver stalling: park in the skid slot
            skid_in = rsp_new;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_pop) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   // register map
   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= '0;
         long_ff <= IDLE_HOLD_RESET;
         short_ff <= BIT_SPACING_RESET;
         start_ff <= START_GAP_RESET;
      end else if (csr_write) begin
         if (csr_port.index inside {[CSR_TX_WORD_0:CSR_TX_WORD_4]}) begin
            words_ff[csr_port.index[WORD_IDX_W-1:0]] <= csr_port.data;
         end else begin
            case (csr_port.index)
               CSR_IDLE_HOLD: begin
                  long_ff <= csr_port.data[TICKS_W-1:0];
               end
               CSR_BIT_SPACING: begin
                  short_ff <= csr_port.data[TICKS_W-1:0];
               end
               CSR_START_GAP: begin
                  start_ff <= csr_port.data[TICKS_W-1:0];
               end
               default: begin
                  // unmapped index, write dropped
               end
            endcase
         end
      end
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.tx_line = out_ff.tx_line;
   assign rsp_port.rx_bit_valid = out_ff.rx_bit_valid;
   assign rsp_port.rx_bit = out_ff.rx_bit;
   assign rsp_port.word_start_valid = out_ff.word_start_valid;
   assign rsp_port.word_low_byte = out_ff.word_low_byte;
endmodule
